/* rtl/core/pps_pkg.sv */
// shared types and constants of the preemptive priority scheduler
package pps_pkg;

  localparam int TABLE_SLOTS = 16;
  localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_SLOTS - 1);

  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 104;

  localparam logic CMD_ADMIT = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RAN = 3'd1;
  localparam logic [2:0] ST_FINISHED = 3'd2;
  localparam logic [2:0] ST_ADMITTED = 3'd3;
  localparam logic [2:0] ST_FULL = 3'd4;

  typedef struct packed {
    logic [31:0] order;
    logic [31:0] admit_time;
    logic [15:0] burst;
    logic [15:0] remaining;
    logic [7:0]  prio;
    logic [7:0]  task_id;
  } slot_t;

  typedef struct packed {
    logic              accept;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              cmp_en;
    logic              calc;
    logic              do_admit;
    logic              do_tick;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

/* rtl/core/preemptive_priority_scheduler.sv */
// preemptive priority scheduler top level
// An admit beat places a task in the lowest free slot of a 16-entry table (or reports it full); a
// tick beat scans the table one slot per cycle through the slot memory's single read port,
// picks the valid task with the lowest priority number (older admission wins ties) and runs
// it for one time unit. One beat is taken at a time; a result waits in the output register
// while the next beat is accepted. Every beat gives exactly one result beat with its status in
// m_tuser.
module preemptive_priority_scheduler (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // task_id, task_priority, burst_length
  input  logic [0:0]   s_tuser,   // command
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // ran_task, done_time, turnaround, waiting
  output logic [2:0]   m_tuser    // status
);
  import pps_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  pps_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_command (s_tuser[0]),
    .in_ready   (s_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  pps_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_data    (s_tdata),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (m_tdata),
    .out_status (m_tuser)
  );

endmodule

/* rtl/core/pps_ctrl.sv */
// sequencer for admit and tick commands
module pps_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_command,
  output logic             in_ready,
  input  pps_pkg::dp_stat_t stat,
  output pps_pkg::dp_cmd_t  cmd
);
  import pps_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADMIT,
    S_SCAN,
    S_SCAN_END,
    S_CALC,
    S_TICK
  } state_t;

  state_t            state;
  logic [SLOT_W-1:0] scan_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      scan_cnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            scan_cnt <= '0;
            state <= (in_command == CMD_ADMIT) ? S_ADMIT : S_SCAN;
          end
        end
        S_ADMIT: begin
          if (stat.out_free) state <= S_IDLE;
        end
        S_SCAN: begin
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt == SLOT_LAST) state <= S_SCAN_END;
        end
        S_SCAN_END: state <= S_CALC;
        S_CALC: state <= S_TICK;
        S_TICK: begin
          if (stat.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.accept = (state == S_IDLE) && in_valid;
    cmd.rd_en = (state == S_SCAN);
    cmd.rd_addr = scan_cnt;
    // compare runs in the cycle after the read
    cmd.cmp_en = ((state == S_SCAN) && (scan_cnt != '0)) || (state == S_SCAN_END);
    cmd.calc = (state == S_CALC);
    cmd.do_admit = (state == S_ADMIT) && stat.out_free;
    cmd.do_tick = (state == S_TICK) && stat.out_free;
  end

endmodule

/* rtl/core/pps_datapath.sv */
// task table, priority scan and result register
module pps_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  pps_pkg::dp_cmd_t                   cmd,
  output pps_pkg::dp_stat_t                  stat,
  input  logic [pps_pkg::IN_DATA_W-1:0]      in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pps_pkg::OUT_DATA_W-1:0]     out_data,
  output logic [2:0]                         out_status
);
  import pps_pkg::*;

  slot_t             mem [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] slot_valid;

  logic [7:0]        in_id;
  logic [7:0]        in_prio;
  logic [15:0]       in_burst;

  logic [31:0]       current_time;
  logic [31:0]       admit_counter;

  slot_t             rd_data;
  logic              rd_valid;
  logic [SLOT_W-1:0] rd_idx;

  logic              best_found;
  slot_t             best;
  logic [SLOT_W-1:0] best_idx;
  logic [31:0]       best_age;

  logic [31:0]       fin_r;
  logic [31:0]       tat_r;
  logic [15:0]       rem_next;

  logic [7:0]        out_task;
  logic [31:0]       out_fin;
  logic [31:0]       out_tat;
  logic [31:0]       out_wt;

  logic              free_found;
  logic [SLOT_W-1:0] free_idx;
  logic [31:0]       cand_age;
  logic              better;
  slot_t             admit_word;
  slot_t             ran_word;

  // lowest-numbered free slot
  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int k = TABLE_SLOTS - 1; k >= 0; k--) begin
      if (!slot_valid[k]) begin
        free_found = 1'b1;
        free_idx = SLOT_W'(k);
      end
    end
  end

  assign cand_age = admit_counter - rd_data.order;
  assign better = rd_valid && (!best_found || (rd_data.prio < best.prio) ||
                  ((rd_data.prio == best.prio) && (cand_age > best_age)));

  always_comb begin
    admit_word = '0;
    admit_word.order = admit_counter;
    admit_word.admit_time = current_time;
    admit_word.burst = in_burst;
    admit_word.remaining = in_burst;
    admit_word.prio = in_prio;
    admit_word.task_id = in_id;
    ran_word = best;
    ran_word.remaining = rem_next;
  end

  // slot memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.do_admit && free_found) begin
      mem[free_idx] <= admit_word;
    end else if (cmd.do_tick && best_found && (rem_next != '0)) begin
      mem[best_idx] <= ran_word;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      current_time <= '0;
      admit_counter <= '0;
      best_found <= 1'b0;
      rd_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.do_admit || cmd.do_tick) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.rd_en) rd_valid <= slot_valid[cmd.rd_addr];
      if (cmd.accept) begin
        best_found <= 1'b0;
      end else if (cmd.cmp_en && better) begin
        best_found <= 1'b1;
      end
      if (cmd.do_admit) begin
        if (free_found) begin
          slot_valid[free_idx] <= 1'b1;
          admit_counter <= admit_counter + 32'd1;
        end
      end
      if (cmd.do_tick) begin
        current_time <= fin_r;
        if (best_found && (rem_next == '0)) slot_valid[best_idx] <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_id <= in_data[7:0];
      in_prio <= in_data[15:8];
      in_burst <= in_data[31:16];
    end
    if (cmd.rd_en) rd_idx <= cmd.rd_addr;
    if (cmd.cmp_en && better) begin
      best <= rd_data;
      best_idx <= rd_idx;
      best_age <= cand_age;
    end
    if (cmd.calc) begin
      fin_r <= current_time + 32'd1;
      tat_r <= current_time - best.admit_time + 32'd1;
      // zero burst saturates at zero
      rem_next <= (best.remaining == '0) ? '0 : best.remaining - 16'd1;
    end
    if (cmd.do_admit) begin
      out_status <= free_found ? ST_ADMITTED : ST_FULL;
      out_task <= in_id;
      out_fin <= '0;
      out_tat <= '0;
      out_wt <= '0;
    end
    if (cmd.do_tick) begin
      if (!best_found) begin
        out_status <= ST_IDLE;
        out_task <= '0;
        out_fin <= '0;
        out_tat <= '0;
        out_wt <= '0;
      end else if (rem_next == '0) begin
        out_status <= ST_FINISHED;
        out_task <= best.task_id;
        out_fin <= fin_r;
        out_tat <= tat_r;
        out_wt <= tat_r - {16'd0, best.burst};
      end else begin
        out_status <= ST_RAN;
        out_task <= best.task_id;
        out_fin <= '0;
        out_tat <= '0;
        out_wt <= '0;
      end
    end
  end

  assign stat.out_free = !out_valid || out_ready;
  assign out_data = {out_wt, out_tat, out_fin, out_task};

endmodule
